// File: sv/rq8_pkg.sv
// ---------------------------------------------------------------------------
// rq8_pkg
// Shared types, constants and helper functions for the int8 requantiser.
// ---------------------------------------------------------------------------
package rq8_pkg;

   localparam int ACC_W  = 32;
   localparam int ZP_W   = 32;
   localparam int Q_W    = 8;
   localparam int SIG_W  = 25;   // rounded accumulator significand, may carry to 2^24
   localparam int PROD_W = 48;   // accumulator times scale significand
   localparam int EXP_W  = 10;   // signed binary exponents

   localparam logic signed [Q_W-1:0] OUT_MIN = -8'sd128;
   localparam logic signed [Q_W-1:0] OUT_MAX = 8'sd127;

   localparam logic signed [ACC_W-1:0] SAT_POS = 32'sh7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] SAT_NEG = 32'sh8000_0000;

   localparam logic signed [EXP_W-1:0] EXP_SUB  = -10'sd149;  // subnormal exponent
   localparam logic signed [EXP_W-1:0] EXP_BIAS = 10'sd150;   // bias plus fraction width

   // side information carried alongside the arithmetic
   typedef struct packed {
      logic                   neg;      // sign of the product
      logic                   is_inf;   // scale is infinity, product is not NaN
      logic                   is_nan;   // product is NaN
      logic                   last;
      logic signed [ZP_W-1:0] zp;
   } side_type;

   // index of the highest set bit (0 for zero)
   function automatic logic [4:0] top_bit32(input logic [31:0] x);
      logic [4:0] t;
      t = '0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) t = 5'(i);
      end
      return t;
   endfunction

   function automatic logic [5:0] top_bit48(input logic [PROD_W-1:0] x);
      logic [5:0] t;
      t = '0;
      for (int i = 0; i < PROD_W; i++) begin
         if (x[i]) t = 6'(i);
      end
      return t;
   endfunction

   // x / 2^n rounded to nearest, ties to even; n >= 1
   function automatic logic [PROD_W-1:0] rne_shift(input logic [PROD_W-1:0] x,
                                                   input logic [5:0] n);
      logic [PROD_W-1:0] q;
      logic [PROD_W-1:0] rem;
      logic [PROD_W-1:0] half;
      q    = x >> n;
      rem  = x & ((PROD_W'(1) << n) - PROD_W'(1));
      half = PROD_W'(1) << (n - 6'd1);
      if (rem > half || (rem == half && q[0])) q = q + PROD_W'(1);
      return q;
   endfunction

endpackage

// File: sv/requantize_int32_to_int8_relu_unit.sv
// ---------------------------------------------------------------------------
// requantize_int32_to_int8_relu_unit
// Int32 accumulator times float32 scale, rounded to int, plus zero point,
// clamped to int8 with optional ReLU. Seven-stage pipeline.
// ---------------------------------------------------------------------------
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid req_stall + four fields       | in
//   rsp     | rsp_valid rsp_stall rsp_quantized/last  | out
//   csr     | csr_valid csr_ready csr_activation_mode | in
//
// One beat per cycle sustained while rsp is not stalled; the stage registers
// are decode, int-to-float round, multiply, normalise, float round,
// float-to-int, zero point and clamp.
// Synchronous reset clears the valid bits and the activation mode.
// rsp_stall with rsp_valid high freezes every stage together and is passed back as req_stall.
// ---------------------------------------------------------------------------
module requantize_int32_to_int8_relu_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rq8_pkg::ACC_W-1:0]    req_accumulator,
   input  logic        [31:0]                  req_scale_bits,
   input  logic signed [rq8_pkg::ZP_W-1:0]     req_zero_point,
   input  logic                                req_last_in_chunk,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rq8_pkg::Q_W-1:0]      rsp_quantized,
   output logic                                rsp_last_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_activation_mode
);
   import rq8_pkg::*;

   logic advance;
   logic act_mode_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;

   // stage 1: decode
   logic [31:0]            mag_in;
   logic                   neg_a_in;
   logic [7:0]             ef_in;
   logic [22:0]            frac_in;
   side_type               side1_in;
   logic [31:0]            mag1_ff;
   logic [4:0]             p1_ff;
   logic [23:0]            sigs1_ff;
   logic signed [EXP_W-1:0] exps1_ff;
   side_type               side1_ff;

   // stage 2: accumulator to float32
   logic [PROD_W-1:0]      r2_in;
   logic [SIG_W-1:0]       siga2_in;
   logic [3:0]             expa2_in;
   logic [SIG_W-1:0]       siga2_ff;
   logic [23:0]            sigs2_ff;
   logic signed [EXP_W-1:0] e2_ff;
   side_type               side2_ff;

   // stage 3: multiply
   logic [PROD_W:0]        full3_in;
   logic [PROD_W-1:0]      prod3_ff;
   logic signed [EXP_W-1:0] e3_ff;
   side_type               side3_ff;

   // stage 4: find the rounding position
   logic signed [EXP_W-1:0] shraw4_in;
   logic signed [EXP_W-1:0] lim4_in;
   logic [PROD_W-1:0]      prod4_ff;
   logic signed [EXP_W-1:0] sh4_ff;
   logic signed [EXP_W-1:0] e4_ff;
   side_type               side4_ff;

   // stage 5: round to float32 precision
   logic [PROD_W-1:0]      r5_in;
   logic [SIG_W-1:0]       q5_in;
   logic signed [EXP_W-1:0] f5_in;
   logic [SIG_W-1:0]       q5_ff;
   logic signed [EXP_W-1:0] f5_ff;
   side_type               side5_ff;

   // stage 6: float32 to saturated int32
   logic [4:0]             tq6_in;
   logic signed [EXP_W-1:0] nf6_in;
   logic [PROD_W-1:0]      r6_in;
   logic [30:0]            mag6_in;
   logic                   sat6_in;
   logic signed [ACC_W-1:0] res6_in;
   logic signed [ACC_W-1:0] res6_ff;
   side_type               side6_ff;

   // stage 7: zero point, clamp, activation
   logic signed [ACC_W+1:0] sum7_in;
   logic signed [Q_W-1:0]  q7_in;
   logic signed [Q_W-1:0]  q7_ff;
   logic                   last7_ff;

   assign advance   = !(v7_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = v7_ff;
   assign rsp_quantized = q7_ff;
   assign rsp_last_out  = last7_ff;

   // ---- stage 1 ----
   always_comb begin
      neg_a_in = req_accumulator[ACC_W-1];
      mag_in   = neg_a_in ? 32'(-req_accumulator) : 32'(req_accumulator);
      ef_in    = req_scale_bits[30:23];
      frac_in  = req_scale_bits[22:0];
      side1_in.neg    = neg_a_in ^ req_scale_bits[31];
      side1_in.is_nan = (ef_in == 8'hFF) && (frac_in != '0 || mag_in == '0);
      side1_in.is_inf = (ef_in == 8'hFF) && !(frac_in != '0 || mag_in == '0);
      side1_in.last   = req_last_in_chunk;
      side1_in.zp     = req_zero_point;
   end

   // ---- stage 2 ----
   always_comb begin
      r2_in = rne_shift({16'b0, mag1_ff}, 6'(p1_ff) - 6'd23);
      if (p1_ff > 5'd23) begin
         siga2_in = r2_in[SIG_W-1:0];
         expa2_in = 4'(p1_ff - 5'd23);
      end else begin
         siga2_in = mag1_ff[SIG_W-1:0];
         expa2_in = '0;
      end
   end

   // ---- stage 3 ----
   assign full3_in = siga2_ff * sigs2_ff;

   // ---- stage 4: sh = max(top - 23, -149 - e), always within -23..24 ----
   always_comb begin
      shraw4_in = $signed({4'b0, top_bit48(prod3_ff)}) - 10'sd23;
      lim4_in   = EXP_SUB - e3_ff;
   end

   // ---- stage 5 ----
   always_comb begin
      r5_in = rne_shift(prod4_ff, 6'(sh4_ff));
      if (sh4_ff <= 10'sd0) begin
         q5_in = prod4_ff[SIG_W-1:0];
         f5_in = e4_ff;
      end else begin
         q5_in = r5_in[SIG_W-1:0];
         f5_in = e4_ff + sh4_ff;
      end
   end

   // ---- stage 6 ----
   always_comb begin
      tq6_in  = top_bit32({7'b0, q5_ff});
      nf6_in  = -f5_ff;
      r6_in   = rne_shift({23'b0, q5_ff}, 6'(nf6_in));
      mag6_in = '0;
      sat6_in = 1'b0;
      if (q5_ff == '0) begin
         mag6_in = '0;
      end else if (f5_ff >= 10'sd0) begin
         if ($signed({5'b0, tq6_in}) + f5_ff >= 10'sd31) sat6_in = 1'b1;
         else mag6_in = 31'(q5_ff) << f5_ff[4:0];
      end else if (nf6_in >= 10'sd26) begin
         mag6_in = '0;
      end else begin
         mag6_in = r6_in[30:0];
      end

      if (side5_ff.is_nan)      res6_in = SAT_POS;
      else if (side5_ff.is_inf || sat6_in) res6_in = side5_ff.neg ? SAT_NEG : SAT_POS;
      else if (side5_ff.neg)    res6_in = -$signed({1'b0, mag6_in});
      else                      res6_in = $signed({1'b0, mag6_in});
   end

   // ---- stage 7 ----
   always_comb begin
      sum7_in = (ACC_W+2)'(res6_ff) + (ACC_W+2)'(side6_ff.zp);
      if (sum7_in < (ACC_W+2)'(OUT_MIN))      q7_in = OUT_MIN;
      else if (sum7_in > (ACC_W+2)'(OUT_MAX)) q7_in = OUT_MAX;
      else                                    q7_in = sum7_in[Q_W-1:0];
      if (act_mode_ff && q7_in[Q_W-1]) q7_in = '0;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         act_mode_ff <= 1'b0;
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) act_mode_ff <= csr_activation_mode;
         if (advance) begin
            v1_ff <= req_valid;
            v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
            v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff;
         end
      end
   end

   // datapath: hold everything while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         mag1_ff  <= mag_in;
         p1_ff    <= top_bit32(mag_in);
         sigs1_ff <= (ef_in == 8'h00) ? {1'b0, frac_in} : {1'b1, frac_in};
         exps1_ff <= (ef_in == 8'h00) ? EXP_SUB : $signed({2'b0, ef_in}) - EXP_BIAS;
         side1_ff <= side1_in;

         siga2_ff <= siga2_in;
         sigs2_ff <= sigs1_ff;
         e2_ff    <= exps1_ff + $signed({6'b0, expa2_in});
         side2_ff <= side1_ff;

         prod3_ff <= full3_in[PROD_W-1:0];
         e3_ff    <= e2_ff;
         side3_ff <= side2_ff;

         prod4_ff <= prod3_ff;
         sh4_ff   <= (lim4_in > shraw4_in) ? lim4_in : shraw4_in;
         e4_ff    <= e3_ff;
         side4_ff <= side3_ff;

         q5_ff    <= q5_in;
         f5_ff    <= f5_in;
         side5_ff <= side4_ff;

         res6_ff  <= res6_in;
         side6_ff <= side5_ff;

         q7_ff    <= q7_in;
         last7_ff <= side6_ff.last;
      end
   end

endmodule
